### sv/mlf_pkg.sv
// Package for the MAC learning forwarder: item payload types, the
// controller/datapath command and status structs, and fixed constants.
// No dependencies.
`default_nettype none

package mlf_pkg;

  localparam int MAC_W   = 48;
  localparam int PORT_W  = 16;
  localparam int ETYPE_W = 16;
  localparam int ENTRY_W = MAC_W + PORT_W;

  // The I/G bit of a MAC address as it sits in the 48-bit word.
  localparam int GROUP_BIT = 40;

  localparam logic [ETYPE_W-1:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [ETYPE_W-1:0] ETYPE_TUNNEL = 16'hAAAA;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ENCAP = 2'd1;
  localparam logic [1:0] ACT_DECAP = 2'd2;

  typedef struct packed {
    logic [MAC_W-1:0]   src_mac;
    logic [MAC_W-1:0]   dst_mac;
    logic [PORT_W-1:0]  in_port;
    logic [ETYPE_W-1:0] ethertype;
  } mlf_in_t;

  typedef struct packed {
    logic              flood;
    logic [PORT_W-1:0] egress_port;
    logic [1:0]        tunnel_action;
    logic              learn_dropped;
  } mlf_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } mlf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } mlf_status_t;

endpackage

`default_nettype wire

### sv/mlf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module mlf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/mlf_ctrl.sv
// Controller of the MAC learning forwarder: sequences accept, table scan
// and result/learn write. Depends on mlf_pkg.
`default_nettype none

module mlf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mlf_pkg::mlf_status_t status,
  output mlf_pkg::mlf_cmd_t        cmd
);
  import mlf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### sv/mlf_dp.sv
// Datapath of the MAC learning forwarder: item capture, learning table
// scan and compare, learn write and the output register.
// Depends on mlf_pkg and mlf_ram.
`default_nettype none

module mlf_dp #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mlf_pkg::mlf_in_t  in_data,
  input  wire mlf_pkg::mlf_cmd_t cmd,
  output mlf_pkg::mlf_status_t   status,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mlf_pkg::mlf_out_t      out_data
);
  import mlf_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  mlf_in_t           item;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic              cmp_vld;
  logic [AW-1:0]     cmp_addr;
  logic              src_hit;
  logic [AW-1:0]     src_slot;
  logic              dst_hit;
  logic [PORT_W-1:0] dst_port;

  logic [ENTRY_W-1:0] rdata;
  logic [MAC_W-1:0]   rd_mac;
  logic [PORT_W-1:0]  rd_port;

  logic     full;
  logic     src_uni;
  logic     dst_uni;
  logic     learn_any;
  logic     learn_new;
  logic     ram_we;
  logic [AW-1:0] waddr;
  mlf_out_t result;

  assign rd_mac  = rdata[ENTRY_W-1:PORT_W];
  assign rd_port = rdata[PORT_W-1:0];

  assign full      = (count == CW'(TABLE_ENTRIES));
  assign src_uni   = !item.src_mac[GROUP_BIT];
  assign dst_uni   = !item.dst_mac[GROUP_BIT];
  assign learn_new = src_uni && !src_hit && !full;
  assign learn_any = src_uni && (src_hit || !full);
  assign ram_we    = cmd.finish && learn_any;
  assign waddr     = src_hit ? src_slot : count[AW-1:0];

  assign status.scan_done = (idx == count);
  assign status.out_busy  = out_valid && out_stall;

  always_comb begin
    result               = '0;
    result.learn_dropped = src_uni && !src_hit && full;
    case (item.ethertype)
      ETYPE_IPV4:   result.tunnel_action = ACT_ENCAP;
      ETYPE_TUNNEL: result.tunnel_action = ACT_DECAP;
      default:      result.tunnel_action = ACT_NONE;
    endcase
    if (dst_uni && learn_any && (item.dst_mac == item.src_mac)) begin
      result.egress_port = item.in_port;
    end else if (dst_uni && dst_hit) begin
      result.egress_port = dst_port;
    end else begin
      result.flood = 1'b1;
    end
  end

  mlf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata({item.src_mac, item.in_port}),
    .re   (cmd.scan),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (learn_new) begin
          count <= count + CW'(1);
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= in_data;
      idx     <= '0;
      src_hit <= 1'b0;
      dst_hit <= 1'b0;
    end
    if (cmd.scan) begin
      idx      <= idx + CW'(1);
      cmp_addr <= idx[AW-1:0];
    end
    if (cmp_vld) begin
      if (rd_mac == item.src_mac) begin
        src_hit  <= 1'b1;
        src_slot <= cmp_addr;
      end
      if (rd_mac == item.dst_mac) begin
        dst_hit  <= 1'b1;
        dst_port <= rd_port;
      end
    end
    if (cmd.finish) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### sv/mac_learning_forwarder.sv
// Top level of the MAC learning forwarder: joins controller and datapath.
// Depends on mlf_pkg, mlf_ctrl and mlf_dp.
//
// Each input item is one frame header (source and destination MAC, ingress
// port, ethertype); each item gives exactly one result item with the flood
// flag, the egress port, the tunnel action and the learn-dropped flag.
// Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low.
// The learning table lives in one RAM and is searched linearly over the
// entries learned so far, one entry per cycle, through its single read
// port. An item is not accepted until the previous item has finished its
// scan and handed its result to the output register.
// The table holds at most TABLE_ENTRIES entries, so a scan reads at most
// TABLE_ENTRIES entries per item.
// The result sits in an output register, so a new item is taken while a
// result still waits. If the receiver stalls, the block holds its next
// result until the output register is free.
// Reset empties the table at once by clearing the entry count; no clearing
// pass is needed.
`default_nettype none

module mac_learning_forwarder #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire mlf_pkg::mlf_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output mlf_pkg::mlf_out_t     out_data
);
  import mlf_pkg::*;

  mlf_cmd_t    cmd;
  mlf_status_t status;

  mlf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  mlf_dp #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### sv/mlf_checker.sv
// Port-level checks for the MAC learning forwarder, bound to its top level.
// Depends on mlf_pkg and mac_learning_forwarder.
`default_nettype none

module mlf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire mlf_pkg::mlf_out_t out_data,
  input wire logic              out_valid,
  input wire logic              out_stall
);
  import mlf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled output item was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Stalled output item changed.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output item present right after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input accepted again before the item was processed.");

  a_flood_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.flood |-> out_data.egress_port == '0)
    else $error("Flooded item carries a nonzero egress port.");

endmodule

bind mac_learning_forwarder mlf_checker u_mlf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_data (out_data),
  .out_valid(out_valid),
  .out_stall(out_stall)
);

`default_nettype wire
